>>> src/knn_pkg.sv
package knn_pkg;

  localparam int ELEM_W = 16;
  localparam int ID_W   = 20;
  localparam int ACC_W  = 44;
  localparam int CNT_W  = 7;
  localparam int RANK_W = 6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_METRIC = 2'd0;
  localparam logic [1:0] CFG_K      = 2'd1;
  localparam logic [1:0] CFG_RANK   = 2'd2;

  typedef struct packed {
    logic signed [ELEM_W-1:0] row_elem;
    logic signed [ELEM_W-1:0] cand_elem;
    logic [ID_W-1:0]          row_id;
    logic [ID_W-1:0]          cand_id;
    logic                     last_element;
    logic                     last_candidate;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]         neighbour_id;
    logic signed [ACC_W-1:0] distance_key;
    logic [RANK_W-1:0]       rank;
    logic                    is_threshold;
    logic                    status;
    logic                    last;
  } out_item_t;

  // One finished candidate handed from the front end to the list manager.
  typedef struct packed {
    logic signed [ACC_W-1:0] key;
    logic [ID_W-1:0]         id;
    logic                    offer;
    logic                    last_cand;
  } offer_t;

  // Strict lexicographic (key, id) order.
  function automatic logic pair_less(logic signed [ACC_W-1:0] ka, logic [ID_W-1:0] ia,
                                     logic signed [ACC_W-1:0] kb, logic [ID_W-1:0] ib);
    return (ka < kb) || ((ka == kb) && (ia < ib));
  endfunction

endpackage

>>> src/knn_ram.sv
module knn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/knn_fifo.sv
module knn_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  knn_pkg::offer_t din,
  output logic            almost_full,
  input  logic            pop,
  output knn_pkg::offer_t dout,
  output logic            empty
);
  import knn_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  offer_t        mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  // Two transfers may still be on their way from the front end.
  assign almost_full = (cnt_r >= (PW+1)'(DEPTH - 2));
  assign empty       = (cnt_r == '0);
  assign dout        = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

>>> src/knn_front.sv
module knn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  knn_pkg::in_item_t in_item,
  input  logic              metric_is_ip,
  output logic              push,
  output knn_pkg::offer_t   offer
);
  import knn_pkg::*;

  localparam int PROD_W = 2 * ELEM_W;

  // Stage one: products.
  logic                     v1_r;
  logic signed [PROD_W-1:0] p_dot_r, p_rr_r, p_cc_r;
  logic [ID_W-1:0]          id1_r;
  logic                     self1_r, le1_r, lc1_r;

  // Stage two: running sums.
  logic signed [ACC_W-1:0]  dot_r, dot_nxt, rn_r, rn_nxt, cn_r, cn_nxt;
  logic                     clr_r, fin_r;
  logic [ID_W-1:0]          id2_r;
  logic                     self2_r, lc2_r;
  logic signed [ACC_W-1:0]  key_l2;

  always_comb begin
    dot_nxt = (clr_r ? '0 : dot_r) + ACC_W'(p_dot_r);
    rn_nxt  = (clr_r ? '0 : rn_r) + ACC_W'(p_rr_r);
    cn_nxt  = (clr_r ? '0 : cn_r) + ACC_W'(p_cc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fin_r <= 1'b0;
      clr_r <= 1'b1;
    end else begin
      v1_r  <= in_valid;
      fin_r <= v1_r && le1_r;
      if (v1_r) begin
        clr_r <= le1_r;
      end
    end
    if (in_valid) begin
      p_dot_r <= in_item.row_elem * in_item.cand_elem;
      p_rr_r  <= in_item.row_elem * in_item.row_elem;
      p_cc_r  <= in_item.cand_elem * in_item.cand_elem;
      id1_r   <= in_item.cand_id;
      self1_r <= (in_item.cand_id == in_item.row_id);
      le1_r   <= in_item.last_element || in_item.last_candidate;
      lc1_r   <= in_item.last_candidate;
    end
    if (v1_r) begin
      dot_r   <= dot_nxt;
      rn_r    <= rn_nxt;
      cn_r    <= cn_nxt;
      id2_r   <= id1_r;
      self2_r <= self1_r;
      lc2_r   <= lc1_r;
    end
  end

  // Stage three: the key of a finished candidate goes to the queue.
  assign key_l2          = rn_r + cn_r - (dot_r <<< 1);
  assign push            = fin_r;
  assign offer.key       = metric_is_ip ? -dot_r : key_l2;
  assign offer.id        = id2_r;
  assign offer.offer     = !self2_r;
  assign offer.last_cand = lc2_r;

endmodule

>>> src/knn_back.sv
module knn_back #(
  parameter int K_MAX = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  knn_pkg::offer_t    q_data,
  output logic               q_pop,
  input  logic [6:0]         k_count,
  input  logic [6:0]         rank_k,
  output logic               out_empty,
  input  logic               out_pop,
  output knn_pkg::out_item_t out_data
);
  import knn_pkg::*;

  localparam int AW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int EW  = ACC_W + ID_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MAXS, S_REPL, S_CHECK, S_SORT, S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, iss_r, iss_nxt, rank_r, rank_nxt, k_eff;
  offer_t               ent_r, ent_nxt;
  logic                 rd_v_r, rd_v_nxt, best_v_r, best_v_nxt;
  logic [AW-1:0]        rd_idx_r, rd_idx_nxt, best_idx_r, best_idx_nxt;
  logic signed [ACC_W-1:0] best_key_r, best_key_nxt, d_key;
  logic [ID_W-1:0]      best_id_r, best_id_nxt, d_id;
  logic [K_MAX-1:0]     done_r, done_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;
  logic                 we, take, scan_end, out_free, is_last;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata, rdata;

  knn_ram #(.WIDTH(EW), .DEPTH(K_MAX)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (iss_r[AW-1:0]),
    .rdata (rdata)
  );

  // Effective list length.
  always_comb begin
    if (k_count == '0) begin
      k_eff = CNT_W'(1);
    end else if (k_count > CNT_W'(K_MAX)) begin
      k_eff = CNT_W'(K_MAX);
    end else begin
      k_eff = k_count;
    end
  end

  assign d_key     = rdata[EW-1:ID_W];
  assign d_id      = rdata[ID_W-1:0];
  assign scan_end  = rd_v_r && (CNT_W'(rd_idx_r) == cnt_r - 1'b1);
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign is_last   = (rank_r + 1'b1 == k_eff);

  // Scan selection: largest pair for a replacement, smallest open pair for output.
  always_comb begin
    if (state_r == S_MAXS) begin
      take = !best_v_r || pair_less(best_key_r, best_id_r, d_key, d_id);
    end else begin
      take = !done_r[rd_idx_r] && (!best_v_r || pair_less(d_key, d_id, best_key_r, best_id_r));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    rank_nxt      = rank_r;
    ent_nxt       = ent_r;
    best_v_nxt    = best_v_r;
    best_idx_nxt  = best_idx_r;
    best_key_nxt  = best_key_r;
    best_id_nxt   = best_id_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = cnt_r[AW-1:0];
    wdata         = {ent_r.key, ent_r.id};
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = iss_r[AW-1:0];

    // Read issue and compare, shared by both scans.
    if ((state_r == S_MAXS || state_r == S_SORT) && iss_r < cnt_r) begin
      rd_v_nxt = 1'b1;
      iss_nxt  = iss_r + 1'b1;
    end
    if ((state_r == S_MAXS || state_r == S_SORT) && rd_v_r && take) begin
      best_v_nxt   = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_key_nxt = d_key;
      best_id_nxt  = d_id;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_data;
          state_nxt = q_data.last_cand ? S_CHECK : S_IDLE;
          if (q_data.offer) begin
            if (cnt_r < k_eff) begin
              we      = 1'b1;
              wdata   = {q_data.key, q_data.id};
              cnt_nxt = cnt_r + 1'b1;
            end else if (cnt_r != '0) begin
              iss_nxt    = '0;
              best_v_nxt = 1'b0;
              state_nxt  = S_MAXS;
            end
          end
        end
      end
      S_MAXS: begin
        if (scan_end) begin
          state_nxt = S_REPL;
        end
      end
      S_REPL: begin
        if (ent_r.key < best_key_r) begin
          we    = 1'b1;
          waddr = best_idx_r;
        end
        state_nxt = ent_r.last_cand ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (cnt_r < k_eff) begin
          // Short list: one error result.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{neighbour_id: '0, distance_key: '0, rank: '0,
                              is_threshold: 1'b0, status: 1'b1, last: 1'b1};
            cnt_nxt       = '0;
            state_nxt     = S_IDLE;
          end
        end else begin
          done_nxt   = '0;
          rank_nxt   = '0;
          iss_nxt    = '0;
          best_v_nxt = 1'b0;
          state_nxt  = S_SORT;
        end
      end
      S_SORT: begin
        if (scan_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.neighbour_id   = best_id_r;
          out_nxt.distance_key   = best_key_r;
          out_nxt.rank           = rank_r[RANK_W-1:0];
          out_nxt.is_threshold   = (rank_k != '0) && (rank_r == rank_k - 1'b1);
          out_nxt.status         = 1'b0;
          out_nxt.last           = is_last;
          done_nxt[best_idx_r]   = 1'b1;
          rank_nxt               = rank_r + 1'b1;
          iss_nxt                = '0;
          best_v_nxt             = 1'b0;
          if (is_last) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SORT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    iss_r      <= iss_nxt;
    rank_r     <= rank_nxt;
    ent_r      <= ent_nxt;
    best_v_r   <= best_v_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    best_id_r  <= best_id_nxt;
    done_r     <= done_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_r      <= out_nxt;
  end

endmodule

>>> src/knn_top_k_select_top.sv
// Channel  Ports                        Moves
// input    in_push, in_full, in_data    one element pair per transfer
// result   out_pop, out_empty, out_data one ranked neighbour per transfer
// config   cfg_we, cfg_addr, cfg_data   one register write per cycle
//
// Element pairs are taken one per cycle while in_full is low; products and sums run in a
// two-stage front end, and a finished candidate is pushed into the queue from the sum stage.
// A finished candidate goes through a four-entry queue to the list manager, which appends it
// while the list is short, or scans for the largest entry and replaces it on a smaller key.
// Output of a row runs one selection scan over the list RAM for each ranked neighbour.
// Reset is synchronous and clears all control state; the list RAM needs no clearing.
// in_full rises while the queue holds two or more candidates.
module knn_top_k_select_top #(
  parameter int K_MAX = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  knn_pkg::in_item_t  in_data,
  input  logic               out_pop,
  output logic               out_empty,
  output knn_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [6:0]         cfg_data
);
  import knn_pkg::*;

  logic       metric_is_ip_r;
  logic [6:0] k_count_r, rank_k_r;
  logic       f_push, q_afull, q_pop, q_empty, in_take;
  offer_t     f_offer, q_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_is_ip_r <= 1'b0;
      k_count_r      <= 7'd32;
      rank_k_r       <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_METRIC: metric_is_ip_r <= cfg_data[0];
        CFG_K:      k_count_r      <= cfg_data;
        CFG_RANK:   rank_k_r       <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign in_full = q_afull;
  assign in_take = in_push && !q_afull;

  knn_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_take),
    .in_item      (in_data),
    .metric_is_ip (metric_is_ip_r),
    .push         (f_push),
    .offer        (f_offer)
  );

  knn_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (f_push),
    .din         (f_offer),
    .almost_full (q_afull),
    .pop         (q_pop),
    .dout        (q_data),
    .empty       (q_empty)
  );

  knn_back #(.K_MAX(K_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .k_count   (k_count_r),
    .rank_k    (rank_k_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> verif/knn_top_k_select_top_tb.sv
module knn_top_k_select_top_tb;
  import knn_pkg::*;

  localparam int LIST_MAX  = 64;
  localparam int DRAIN_LAT = 400;
  localparam int CYCLE_CAP = 4000000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_pop;
  logic      out_empty;
  out_item_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_addr;
  logic [6:0] cfg_data;

  knn_top_k_select_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_pop(out_pop), .out_empty(out_empty), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers and running sums.
  logic                    use_ip;
  logic [6:0]              k_reg;
  logic [6:0]              thr_reg;
  logic [ACC_W-1:0]        dot_sum;
  logic [ACC_W-1:0]        row_sq;
  logic [ACC_W-1:0]        cand_sq;
  logic signed [ACC_W-1:0] held_key [LIST_MAX];
  logic [ID_W-1:0]         held_id [LIST_MAX];
  int                      held_n;

  out_item_t ranked_q[$];
  int        errors;
  int        idle_pct;
  int        items_sent;
  int        cycles;

  // Clock and run limit.
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("knn_top_k_select_top test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic bit key_id_lt(logic signed [ACC_W-1:0] ka, logic [ID_W-1:0] ia,
                                   logic signed [ACC_W-1:0] kb, logic [ID_W-1:0] ib);
    return (ka < kb) || ((ka == kb) && (ia < ib));
  endfunction

  function automatic int kept_limit();
    if (k_reg == 0) return 1;
    if (k_reg > LIST_MAX) return LIST_MAX;
    return int'(k_reg);
  endfunction

  // Keeps the smallest keys; a full list swaps out its largest entry on a strictly smaller key.
  function automatic void offer_key(logic signed [ACC_W-1:0] key, logic [ID_W-1:0] id);
    int mx;
    mx = 0;
    if (held_n < kept_limit()) begin
      held_key[held_n] = key;
      held_id[held_n] = id;
      held_n++;
      return;
    end
    for (int i = 1; i < held_n; i++)
      if (key_id_lt(held_key[mx], held_id[mx], held_key[i], held_id[i])) mx = i;
    if (key < held_key[mx]) begin
      held_key[mx] = key;
      held_id[mx] = id;
    end
  endfunction

  // Emits the sorted neighbour list, or the short-list error result.
  function automatic void emit_row();
    logic signed [ACC_W-1:0] sk [LIST_MAX];
    logic [ID_W-1:0]         si [LIST_MAX];
    int                      k;
    int                      j;
    out_item_t               r;
    k = kept_limit();
    if (held_n < k) begin
      r = '0;
      r.status = 1'b1;
      r.last = 1'b1;
      ranked_q = {ranked_q, r};
      held_n = 0;
      return;
    end
    for (int i = 0; i < held_n; i++) begin
      j = i;
      while (j > 0 && key_id_lt(held_key[i], held_id[i], sk[j-1], si[j-1])) begin
        sk[j] = sk[j-1];
        si[j] = si[j-1];
        j--;
      end
      sk[j] = held_key[i];
      si[j] = held_id[i];
    end
    for (int i = 0; i < k; i++) begin
      r = '0;
      r.neighbour_id = si[i];
      r.distance_key = sk[i];
      r.rank = i[RANK_W-1:0];
      r.is_threshold = (thr_reg != 0) && (i == int'(thr_reg) - 1);
      r.last = (i + 1 == k);
      ranked_q = {ranked_q, r};
    end
    held_n = 0;
  endfunction

  // Accumulates one element pair and closes candidates and rows.
  function automatic void track_element(in_item_t it);
    logic [ACC_W-1:0] key;
    logic             end_cand;
    dot_sum = dot_sum + ACC_W'($signed(it.row_elem) * $signed(it.cand_elem));
    row_sq  = row_sq + ACC_W'($signed(it.row_elem) * $signed(it.row_elem));
    cand_sq = cand_sq + ACC_W'($signed(it.cand_elem) * $signed(it.cand_elem));
    end_cand = it.last_element | it.last_candidate;
    if (!end_cand) return;
    if (it.row_id != it.cand_id) begin
      key = use_ip ? (ACC_W'(0) - dot_sum) : (row_sq + cand_sq - (dot_sum << 1));
      offer_key($signed(key), it.cand_id);
    end
    dot_sum = '0;
    row_sq = '0;
    cand_sq = '0;
    if (it.last_candidate) emit_row();
  endfunction

  // Result side: random pop, each transfer compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (ranked_q.size() == 0) begin
          report_mismatch("unexpected neighbour_id", out_data.neighbour_id, -1);
        end else begin
          want = ranked_q.pop_front();
          if (out_data.neighbour_id !== want.neighbour_id)
            report_mismatch("neighbour_id", out_data.neighbour_id, want.neighbour_id);
          if (out_data.distance_key !== want.distance_key)
            report_mismatch("distance_key", out_data.distance_key, want.distance_key);
          if (out_data.rank !== want.rank)
            report_mismatch("rank", out_data.rank, want.rank);
          if (out_data.is_threshold !== want.is_threshold)
            report_mismatch("is_threshold", out_data.is_threshold, want.is_threshold);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.last !== want.last)
            report_mismatch("last", out_data.last, want.last);
        end
      end
      out_pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Sends one element pair and waits for its transfer.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    track_element(it);
    items_sent++;
  endtask

  function automatic logic signed [15:0] rand_elem(int mode);
    unique case (mode)
      0: return $signed(16'($urandom_range(5))) - 16'sd2;
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One candidate vector; mode picks the element spread, fixed values override it.
  task automatic send_cand(input logic [ID_W-1:0] rid, input logic [ID_W-1:0] cid,
                           input int dim, input bit end_row, input int mode,
                           input bit fixed, input logic signed [15:0] fr,
                           input logic signed [15:0] fc);
    in_item_t it;
    for (int e = 0; e < dim; e++) begin
      it.row_elem = fixed ? fr : rand_elem(mode);
      it.cand_elem = fixed ? fc : rand_elem(mode);
      it.row_id = rid;
      it.cand_id = cid;
      it.last_candidate = end_row && (e == dim - 1);
      it.last_element = (e == dim - 1) && !(it.last_candidate && $urandom_range(3) == 0);
      send_item(it);
    end
  endtask

  // Lets the block settle before a register write.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_LAT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [6:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (addr)
      CFG_METRIC: use_ip = val[0];
      CFG_K:      k_reg = val;
      CFG_RANK:   thr_reg = val;
      default: ;
    endcase
  endtask

  // Field extremes under squared L2, ids at both ends.
  task automatic test_extremes();
    write_reg(CFG_METRIC, 7'd0);
    write_reg(CFG_K, 7'd2);
    write_reg(CFG_RANK, 7'd2);
    send_cand(20'h00000, 20'hfffff, 2, 0, 0, 1, 16'sh7fff, 16'sh8000);
    send_cand(20'h00000, 20'h00001, 1, 0, 0, 1, 16'sh8000, 16'sh8000);
    send_cand(20'h00000, 20'h55555, 1, 1, 0, 1, 16'sh0000, 16'shffff);
  endtask

  // Negated inner product, with ties on the key broken by id.
  task automatic test_inner_product();
    write_reg(CFG_METRIC, 7'd1);
    send_cand(20'h00007, 20'h00003, 1, 0, 0, 1, 16'sh0002, 16'sh0003);
    send_cand(20'h00007, 20'h00002, 1, 0, 0, 1, 16'sh0003, 16'sh0002);
    send_cand(20'h00007, 20'h00001, 1, 1, 0, 1, 16'sh0001, 16'sh0006);
  endtask

  // Self candidate skipped, leaving the list short.
  task automatic test_self_short();
    write_reg(CFG_K, 7'd3);
    send_cand(20'h00042, 20'h00042, 2, 0, 2, 0, 0, 0);
    send_cand(20'h00042, 20'h00010, 2, 0, 2, 0, 0, 0);
    send_cand(20'h00042, 20'h00011, 1, 1, 2, 0, 0, 0);
  endtask

  // Register values outside their range.
  task automatic test_reg_range();
    write_reg(CFG_K, 7'd0);
    write_reg(CFG_RANK, 7'd0);
    send_cand(20'h00001, 20'h00002, 1, 0, 2, 0, 0, 0);
    send_cand(20'h00001, 20'h00003, 1, 1, 2, 0, 0, 0);
    write_reg(CFG_K, 7'd127);
    write_reg(CFG_RANK, 7'd127);
    for (int i = 0; i < 64; i++)
      send_cand(20'h00009, 20'($urandom), 1, i == 63, i % 3, 0, 0, 0);
    write_reg(CFG_K, 7'd64);
    write_reg(CFG_RANK, 7'd64);
    for (int i = 0; i < 66; i++)
      send_cand(20'h00009, 20'($urandom_range(20)), 1, i == 65, 0, 0, 0, 0);
  endtask

  // k_count lowered while a row is still open.
  task automatic test_k_lowered();
    write_reg(CFG_K, 7'd6);
    write_reg(CFG_RANK, 7'd1);
    for (int i = 0; i < 6; i++) send_cand(20'h00100, 20'(i + 1), 2, 0, 2, 0, 0, 0);
    write_reg(CFG_K, 7'd3);
    send_cand(20'h00100, 20'h00020, 2, 1, 2, 0, 0, 0);
  endtask

  // Large sums from longer vectors of extreme elements.
  task automatic test_long_vector();
    write_reg(CFG_METRIC, 7'd1);
    write_reg(CFG_K, 7'd1);
    send_cand(20'h00005, 20'h00006, 48, 1, 0, 1, 16'sh8000, 16'sh8000);
    write_reg(CFG_METRIC, 7'd0);
    send_cand(20'h00005, 20'h00007, 48, 1, 0, 1, 16'sh8000, 16'sh7fff);
  endtask

  // Random rows, mostly well formed, with a stretch of no idling in the middle.
  task automatic test_random_rows();
    int k;
    int ncand;
    int mode;
    logic [ID_W-1:0] rid;
    while (items_sent < 500) begin
      idle_pct = (items_sent % 600 > 250 && items_sent % 600 < 420) ? 0 : 13;
      if ($urandom_range(3) == 0) begin
        idle_pct = 13;
        write_reg(CFG_METRIC, 7'($urandom_range(1)));
        k = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 8);
        write_reg(CFG_K, 7'(k));
        write_reg(CFG_RANK, 7'($urandom_range(10) == 0 ? $urandom : $urandom_range(k + 1)));
      end
      k = kept_limit();
      ncand = k + $urandom_range(8) - 2;
      if (ncand < 1) ncand = 1;
      mode = $urandom_range(2);
      rid = 20'($urandom);
      for (int c = 0; c < ncand; c++)
        send_cand(rid, ($urandom_range(9) == 0) ? rid : 20'($urandom),
                  $urandom_range(1, 4), c == ncand - 1, mode, 0, 0, 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    items_sent = 0;
    idle_pct = 13;
    use_ip = 1'b0;
    k_reg = 7'd32;
    thr_reg = 7'd10;
    dot_sum = '0;
    row_sq = '0;
    cand_sq = '0;
    held_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_inner_product();
    test_self_short();
    test_reg_range();
    test_k_lowered();
    test_long_vector();
    test_random_rows();

    in_push <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_LAT) @(posedge clk);
    if (errors == 0) begin
      $display("knn_top_k_select_top test passed");
    end else begin
      $display("knn_top_k_select_top test failed");
    end
    $finish;
  end

endmodule
